/* rtl/ipk_pkg.sv */
`timescale 1ns / 1ps
package ipk_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIT  = 2'd1;
  localparam logic [1:0] PH_DAH  = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  localparam logic EL_DIT = 1'b0;
  localparam logic EL_DAH = 1'b1;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_START  = 2'd1;
  localparam logic [1:0] EV_FINISH = 2'd2;

  localparam logic [1:0] ARM_NONE = 2'd0;
  localparam logic [1:0] ARM_DIT  = 2'd1;
  localparam logic [1:0] ARM_DAH  = 2'd2;

  localparam logic [1:0] LINE_DIT = 2'd0;
  localparam logic [1:0] LINE_DAH = 2'd1;

  localparam logic [1:0] COMBO_BOTH = 2'd3;

  localparam logic [2:0] REG_SPEED  = 3'd0;
  localparam logic [2:0] REG_DASH   = 3'd1;
  localparam logic [2:0] REG_GAP    = 3'd2;
  localparam logic [2:0] REG_DITW   = 3'd3;
  localparam logic [2:0] REG_WOPEN  = 3'd4;
  localparam logic [2:0] REG_WCLOSE = 3'd5;
  localparam logic [2:0] REG_MODES  = 3'd6;

  localparam int OUT_BITS = 48;
  localparam logic [20:0] DIT_BASE = 21'd1200000;

  // reciprocals for exact floor division of operands below 2^29
  localparam logic [29:0] RECIP_50 = 30'd687194768;  // ceil(2^35 / 50)
  localparam logic [28:0] RECIP_10 = 29'd429496730;  // ceil(2^32 / 10)

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture input item, start work
    logic div_start;   // start base dit divide
    logic mul_dit;     // quotient times dit weight
    logic scale_dit;   // dit length from the weighted quotient
    logic mul_len;     // dit length times dash and gap weights
    logic scale_len;   // dah and gap lengths
    logic win_mul;     // window products
    logic apply;       // commit state and build result
  } ipk_cmd_t;

  typedef struct packed {
    logic div_done;
  } ipk_sts_t;

endpackage

/* rtl/iambic_paddle_keyer.sv */
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_ready  | operation, paddle_line, paddle_active, now_time
// out     | out_valid / out_ready| key_down, element_event, event_element,
//         |                      | event_time, memory_armed, squeeze_detected
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
// the result is offered after the input transfer goes through 21 divider steps for the
// base dit length, four multiply and scale steps, then the commit state.
// one item is in work at a time; in_ready returns the cycle after the result transfers.
// rst is synchronous and restores the default registers and an idle keyer.
// a stalled output holds the result and blocks the next item.
module iambic_paddle_keyer #(
  parameter int TIME_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [1:0]  paddle_line,
  input  logic        paddle_active,
  input  logic [47:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        key_down,
  output logic [1:0]  element_event,
  output logic        event_element,
  output logic [47:0] event_time,
  output logic [1:0]  memory_armed,
  output logic        squeeze_detected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import ipk_pkg::*;

  ipk_cmd_t cmd;
  ipk_sts_t sts;

  assign cfg_ready = 1'b1;

  ipk_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  ipk_datapath #(.TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .operation(operation), .paddle_line(paddle_line),
    .paddle_active(paddle_active), .now_time(now_time),
    .key_down(key_down), .element_event(element_event),
    .event_element(event_element), .event_time(event_time),
    .memory_armed(memory_armed), .squeeze_detected(squeeze_detected)
  );

`ifndef ASSERT_OFF
  // input and output never open together
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input open while result pending");
  // a transfer in closes the input, with no result pending, in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready && !out_valid)
    else $error("item transfer did not start work");
  // an event never comes with a newly armed memory on start
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(element_event == EV_START && memory_armed != ARM_NONE))
    else $error("start event with memory arming");
`endif

endmodule

/* rtl/ipk_ctrl.sv */
`timescale 1ns / 1ps
module ipk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ipk_pkg::ipk_sts_t sts,
  output ipk_pkg::ipk_cmd_t cmd
);
  import ipk_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MDIT  = 3'd2;
  localparam logic [2:0] S_SDIT  = 3'd3;
  localparam logic [2:0] S_MLEN  = 3'd4;
  localparam logic [2:0] S_SLEN  = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state, state_next;
  logic accept;

  assign accept = in_valid && in_ready;
  // one item in flight; input opens again once the result is taken
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_MDIT;
      end
      S_MDIT: begin
        cmd.mul_dit = 1'b1;
        state_next = S_SDIT;
      end
      S_SDIT: begin
        cmd.scale_dit = 1'b1;
        state_next = S_MLEN;
      end
      S_MLEN: begin
        cmd.mul_len = 1'b1;
        state_next = S_SLEN;
      end
      S_SLEN: begin
        cmd.scale_len = 1'b1;
        cmd.win_mul = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

/* rtl/ipk_datapath.sv */
`timescale 1ns / 1ps
module ipk_datapath #(
  parameter int TIME_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  ipk_pkg::ipk_cmd_t cmd,
  output ipk_pkg::ipk_sts_t sts,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              operation,
  input  logic [1:0]        paddle_line,
  input  logic              paddle_active,
  input  logic [47:0]       now_time,
  output logic              key_down,
  output logic [1:0]        element_event,
  output logic              event_element,
  output logic [47:0]       event_time,
  output logic [1:0]        memory_armed,
  output logic              squeeze_detected
);
  import ipk_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int PW = TB + 8;   // width of window products

  // configuration registers
  logic [6:0] wpm, dash_weight, gap_weight, dit_weight;
  logic [6:0] window_open_pct, window_close_pct;
  logic [3:0] keying_modes;

  always_ff @(posedge clk) begin
    if (rst) begin
      wpm <= 7'd20;
      dash_weight <= 7'd30;
      gap_weight <= 7'd50;
      dit_weight <= 7'd50;
      window_open_pct <= 7'd0;
      window_close_pct <= 7'd100;
      keying_modes <= 4'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED:  wpm <= cfg_data;
        REG_DASH:   dash_weight <= cfg_data;
        REG_GAP:    gap_weight <= cfg_data;
        REG_DITW:   dit_weight <= cfg_data;
        REG_WOPEN:  window_open_pct <= cfg_data;
        REG_WCLOSE: window_close_pct <= cfg_data;
        REG_MODES:  keying_modes <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // captured input item
  logic          op_q, act_q;
  logic [1:0]    line_q;
  logic [TB-1:0] now_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      line_q <= paddle_line;
      act_q <= paddle_active;
      now_q <= TB'(now_time);
    end
  end

  // restoring divider, 1200000 / wpm, one quotient bit a cycle
  logic [20:0] div_rem, div_quo;
  logic [4:0]  div_cnt;
  logic        div_busy;
  logic [6:0]  divisor;
  logic [21:0] div_trial;

  assign divisor = (wpm == 7'd0) ? 7'd1 : wpm;
  assign div_trial = {div_rem, div_quo[20]} - {15'd0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt <= 5'd20;
    end else if (div_busy) begin
      if (div_cnt == 5'd0) div_busy <= 1'b0;
      else div_cnt <= div_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= DIT_BASE;
    end else if (div_busy) begin
      if (!div_trial[21]) begin
        div_rem <= div_trial[20:0];
        div_quo <= {div_quo[19:0], 1'b1};
      end else begin
        div_rem <= {div_rem[19:0], div_quo[20]};
        div_quo <= {div_quo[19:0], 1'b0};
      end
    end
  end

  assign sts.div_done = div_busy && (div_cnt == 5'd0);

  // dit length = q * weight / 50, dah = dit * dash / 10, gap = dit * gap / 50
  // each constant divide is a reciprocal multiply
  logic [27:0] dit_prod;
  logic [21:0] dit_len;
  logic [28:0] dah_prod, gap_prod;
  logic [25:0] dah_len;
  logic [22:0] gap_len;
  logic [57:0] dit_scaled, dah_scaled;
  logic [58:0] gap_scaled;

  assign dit_scaled = 58'(dit_prod) * 58'(RECIP_50);
  assign dah_scaled = 58'(dah_prod) * 58'(RECIP_10);
  assign gap_scaled = 59'(gap_prod) * 59'(RECIP_50);

  always_ff @(posedge clk) begin
    if (cmd.mul_dit) dit_prod <= 28'(div_quo) * 28'(dit_weight);
    if (cmd.scale_dit) dit_len <= dit_scaled[56:35];
    if (cmd.mul_len) begin
      dah_prod <= 29'(dit_len) * 29'(dash_weight);
      gap_prod <= 29'(dit_len) * 29'(gap_weight);
    end
    if (cmd.scale_len) begin
      dah_len <= dah_scaled[57:32];
      gap_len <= gap_scaled[57:35];
    end
  end

  // keyer state
  logic [1:0]    phase;
  logic          current_element, previous_element;
  logic [TB-1:0] element_start_time, element_end_time, gap_end_time;
  logic          dit_paddle_down, dah_paddle_down, dit_memory, dah_memory;
  logic          squeeze_seen, queued_valid, queued_element;
  logic [1:0]    reference_combo;

  // window products, registered ahead of the compare
  logic [TB-1:0] dur, elapsed_raw;
  logic [TB:0]   elapsed;
  logic [PW-1:0] el100, open_prod, close_prod;

  assign dur = element_end_time - element_start_time;
  assign elapsed_raw = now_q - element_start_time;

  always_comb begin
    elapsed = '0;
    if (dur != '0 && now_q >= element_start_time) begin
      if ({1'b0, elapsed_raw} > {dur, 1'b0}) elapsed = {dur, 1'b0};
      else elapsed = {1'b0, elapsed_raw};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_mul) begin
      el100 <= PW'(elapsed) * PW'(100);
      open_prod <= PW'(dur) * PW'(window_open_pct);
      close_prod <= PW'(dur) * PW'(window_close_pct);
    end
  end

  // next-state logic for one item
  logic          win_open;
  logic [1:0]    combo, combo_new;
  logic          can_dit, can_dah;
  logic [1:0]    ph_n;
  logic          cur_n, prev_n, dm_n, hm_n, sq_n, qv_n, qe_n;
  logic          dpd_n, hpd_n;
  logic [1:0]    rc_n;
  logic [TB-1:0] est_n, eet_n, get_n;
  logic [1:0]    ev_n, arm_n;
  logic          evel_n, sqd_n;
  logic [TB-1:0] evt_n;
  logic          bonus, bonus_mem, do_idle, start_el, do_start;

  assign win_open = !(el100 < open_prod) && (el100 <= close_prod);
  assign combo = {dah_paddle_down, dit_paddle_down};
  assign can_dit = keying_modes[1];
  assign can_dah = keying_modes[2];

  always_comb begin
    ph_n = phase; cur_n = current_element; prev_n = previous_element;
    dm_n = dit_memory; hm_n = dah_memory; sq_n = squeeze_seen;
    qv_n = queued_valid; qe_n = queued_element;
    dpd_n = dit_paddle_down; hpd_n = dah_paddle_down; rc_n = reference_combo;
    est_n = element_start_time; eet_n = element_end_time; get_n = gap_end_time;
    ev_n = EV_NONE; evel_n = 1'b0; evt_n = '0; arm_n = ARM_NONE; sqd_n = 1'b0;
    bonus = ~current_element; bonus_mem = 1'b0; do_idle = 1'b0;
    start_el = EL_DIT; do_start = 1'b0; combo_new = combo;
    if (!op_q) begin
      if (line_q == LINE_DIT || line_q == LINE_DAH) begin
        if (line_q == LINE_DIT) dpd_n = act_q;
        else hpd_n = act_q;
        combo_new = {hpd_n, dpd_n};
        if (keying_modes[3] || combo_new != 2'd0) rc_n = combo_new;
      end
    end else if (phase == PH_DIT || phase == PH_DAH) begin
      if (win_open) begin
        if (combo == 2'd1 && can_dit && current_element != EL_DIT) begin
          if (!dit_memory) begin dm_n = 1'b1; arm_n = ARM_DIT; end
        end else if (combo == 2'd2 && can_dah && current_element != EL_DAH) begin
          if (!dah_memory) begin hm_n = 1'b1; arm_n = ARM_DAH; end
        end else if (combo == COMBO_BOTH) begin
          if (can_dit && current_element != EL_DIT) dm_n = 1'b1;
          if (can_dah && current_element != EL_DAH) hm_n = 1'b1;
          if (!squeeze_seen) begin sq_n = 1'b1; sqd_n = 1'b1; end
        end
      end
      if (now_q >= element_end_time) begin
        bonus_mem = (bonus == EL_DIT) ? dm_n : hm_n;
        if (dm_n && !qv_n) begin qv_n = 1'b1; qe_n = EL_DIT; end
        if (hm_n && !qv_n) begin qv_n = 1'b1; qe_n = EL_DAH; end
        if (keying_modes[0] && sq_n && reference_combo != COMBO_BOTH && !bonus_mem
            && !qv_n) begin
          qv_n = 1'b1; qe_n = bonus;
        end
        dm_n = 1'b0; hm_n = 1'b0;
        ev_n = EV_FINISH; evel_n = current_element; evt_n = element_end_time;
        ph_n = PH_GAP;
        get_n = element_end_time + TB'(gap_len);
      end
    end else if (phase == PH_GAP) begin
      if (now_q >= gap_end_time) begin
        ph_n = PH_IDLE;
        do_idle = 1'b1;
      end
    end else begin
      do_idle = 1'b1;
    end

    // idle decision: queue first, then paddles
    if (do_idle) begin
      if (queued_valid) begin
        qv_n = 1'b0; do_start = 1'b1; start_el = queued_element;
      end else if (combo == COMBO_BOTH) begin
        do_start = 1'b1; start_el = ~previous_element;
      end else if (combo != 2'd0) begin
        do_start = 1'b1; start_el = (combo == 2'd2) ? EL_DAH : EL_DIT;
      end
    end
    if (do_start) begin
      ph_n = (start_el == EL_DIT) ? PH_DIT : PH_DAH;
      cur_n = start_el; prev_n = start_el;
      est_n = now_q;
      eet_n = now_q + ((start_el == EL_DAH) ? TB'(dah_len) : TB'(dit_len));
      sq_n = 1'b0;
      ev_n = EV_START; evel_n = start_el; evt_n = now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      current_element <= EL_DIT;
      previous_element <= EL_DAH;
      element_start_time <= '0;
      element_end_time <= '0;
      gap_end_time <= '0;
      dit_paddle_down <= 1'b0;
      dah_paddle_down <= 1'b0;
      dit_memory <= 1'b0;
      dah_memory <= 1'b0;
      squeeze_seen <= 1'b0;
      reference_combo <= 2'd0;
      queued_valid <= 1'b0;
      queued_element <= EL_DIT;
    end else if (cmd.apply) begin
      phase <= ph_n;
      current_element <= cur_n;
      previous_element <= prev_n;
      element_start_time <= est_n;
      element_end_time <= eet_n;
      gap_end_time <= get_n;
      dit_paddle_down <= dpd_n;
      dah_paddle_down <= hpd_n;
      dit_memory <= dm_n;
      dah_memory <= hm_n;
      squeeze_seen <= sq_n;
      reference_combo <= rc_n;
      queued_valid <= qv_n;
      queued_element <= qe_n;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      key_down <= (ph_n == PH_DIT || ph_n == PH_DAH);
      element_event <= ev_n;
      event_element <= evel_n;
      event_time <= OUT_BITS'({{(64 - TB){1'b0}}, evt_n});
      memory_armed <= arm_n;
      squeeze_detected <= sqd_n;
    end
  end

endmodule

/* bench/iambic_paddle_keyer_checker.sv */
`timescale 1ns / 1ps
module iambic_paddle_keyer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [1:0]  paddle_line,
  input  logic        paddle_active,
  input  logic [47:0] now_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        key_down,
  input  logic [1:0]  element_event,
  input  logic        event_element,
  input  logic [47:0] event_time,
  input  logic [1:0]  memory_armed,
  input  logic        squeeze_detected,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending_results
);
  import ipk_pkg::*;

  typedef struct packed {
    logic        key;
    logic [1:0]  ev;
    logic        el;
    logic [47:0] t;
    logic [1:0]  armed;
    logic        sq;
  } keyer_result_t;

  localparam logic [63:0] TMASK = 64'hFFFF_FFFF_FFFF;

  keyer_result_t expected_q[$];

  // keyer registers
  logic [6:0] wpm, dash_w, gap_w, dit_w, w_open, w_close;
  logic [3:0] modes;

  // keyer state
  logic [1:0]  ph;
  logic        cur_el, prev_el, dit_pad, dah_pad, dit_mem, dah_mem, sq_seen;
  logic        q_valid, q_el;
  logic [1:0]  ref_combo;
  logic [63:0] el_start, el_end, gap_end;

  function automatic logic [63:0] dit_len();
    logic [63:0] w;
    w = (wpm == 0) ? 64'd1 : 64'(wpm);
    return (64'd1200000 / w) * 64'(dit_w) / 64'd50;
  endfunction

  function automatic logic [1:0] combo();
    return {dah_pad, dit_pad};
  endfunction

  function automatic void begin_element(input logic e, input logic [63:0] t,
                                        inout keyer_result_t r);
    logic [63:0] d;
    d = dit_len();
    if (e == EL_DAH) d = d * 64'(dash_w) / 64'd10;
    ph = (e == EL_DIT) ? PH_DIT : PH_DAH;
    cur_el = e;
    prev_el = e;
    el_start = t;
    el_end = (t + d) & TMASK;
    sq_seen = 1'b0;
    r.ev = EV_START;
    r.el = e;
    r.t = t[47:0];
  endfunction

  function automatic logic in_window(input logic [63:0] now);
    logic [63:0] dur, el;
    dur = (el_end - el_start) & TMASK;
    el = 0;
    if (dur != 0 && now >= el_start) begin
      el = now - el_start;
      if (el > 2 * dur) el = 2 * dur;
    end
    if (el * 100 < 64'(w_open) * dur) return 1'b0;
    return el * 100 <= 64'(w_close) * dur;
  endfunction

  function automatic void enqueue(input logic e);
    if (!q_valid) begin
      q_valid = 1'b1;
      q_el = e;
    end
  endfunction

  function automatic void idle_pick(input logic [63:0] now, inout keyer_result_t r);
    logic [1:0] c;
    c = combo();
    if (q_valid) begin
      q_valid = 1'b0;
      begin_element(q_el, now, r);
    end else if (c == COMBO_BOTH) begin
      begin_element(~prev_el, now, r);
    end else if (c != 0) begin
      begin_element(c == 2'd2 ? EL_DAH : EL_DIT, now, r);
    end
  endfunction

  function automatic keyer_result_t step_keyer(input logic op, input logic [1:0] line,
                                               input logic act, input logic [47:0] nt);
    keyer_result_t r;
    logic [63:0] now;
    logic [1:0] c, mm;
    logic bonus, bonus_mem;
    r = '0;
    now = 64'(nt);
    if (op == 1'b0) begin
      // paddle change
      if (line == LINE_DIT || line == LINE_DAH) begin
        if (line == LINE_DIT) dit_pad = act;
        else dah_pad = act;
        c = combo();
        if (modes[3] || c != 0) ref_combo = c;
      end
    end else if (ph == PH_DIT || ph == PH_DAH) begin
      // memory window
      mm = modes[2:1];
      if (in_window(now)) begin
        c = combo();
        if (c == 2'd1 && mm[0] && cur_el != EL_DIT) begin
          if (!dit_mem) begin dit_mem = 1'b1; r.armed = ARM_DIT; end
        end else if (c == 2'd2 && mm[1] && cur_el != EL_DAH) begin
          if (!dah_mem) begin dah_mem = 1'b1; r.armed = ARM_DAH; end
        end else if (c == COMBO_BOTH) begin
          if (mm[0] && cur_el != EL_DIT) dit_mem = 1'b1;
          if (mm[1] && cur_el != EL_DAH) dah_mem = 1'b1;
          if (!sq_seen) begin sq_seen = 1'b1; r.sq = 1'b1; end
        end
      end
      // element finish
      if (now >= el_end) begin
        bonus = ~cur_el;
        bonus_mem = (bonus == EL_DIT) ? dit_mem : dah_mem;
        if (dit_mem) enqueue(EL_DIT);
        if (dah_mem) enqueue(EL_DAH);
        if (modes[0] && sq_seen && ref_combo != COMBO_BOTH && !bonus_mem) enqueue(bonus);
        dit_mem = 1'b0;
        dah_mem = 1'b0;
        r.ev = EV_FINISH;
        r.el = cur_el;
        r.t = el_end[47:0];
        ph = PH_GAP;
        gap_end = (el_end + dit_len() * 64'(gap_w) / 64'd50) & TMASK;
      end
    end else if (ph == PH_GAP) begin
      if (now >= gap_end) begin
        ph = PH_IDLE;
        idle_pick(now, r);
      end
    end else begin
      idle_pick(now, r);
    end
    r.key = (ph == PH_DIT || ph == PH_DAH);
    return r;
  endfunction

  assign pending_results = expected_q.size();

  always @(posedge clk) begin
    keyer_result_t got, want;
    if (rst) begin
      wpm <= 20; dash_w <= 30; gap_w <= 50; dit_w <= 50;
      w_open <= 0; w_close <= 100; modes <= 4'd7;
      ph = PH_IDLE; cur_el = EL_DIT; prev_el = EL_DAH;
      el_start = 0; el_end = 0; gap_end = 0;
      dit_pad = 0; dah_pad = 0; dit_mem = 0; dah_mem = 0;
      sq_seen = 0; ref_combo = 0; q_valid = 0; q_el = EL_DIT;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED:  wpm <= cfg_data;
          REG_DASH:   dash_w <= cfg_data;
          REG_GAP:    gap_w <= cfg_data;
          REG_DITW:   dit_w <= cfg_data;
          REG_WOPEN:  w_open <= cfg_data;
          REG_WCLOSE: w_close <= cfg_data;
          REG_MODES:  modes <= cfg_data[3:0];
          default: ;
        endcase
      end
      // result transfer
      if (out_valid && out_ready) begin
        got = '{key_down, element_event, event_element, event_time, memory_armed,
                squeeze_detected};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      // input transfer
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(),
                          step_keyer(operation, paddle_line, paddle_active, now_time));
    end
  end

endmodule

/* bench/iambic_paddle_keyer_tb.sv */
`timescale 1ns / 1ps
module iambic_paddle_keyer_tb;
  import ipk_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0, in_ready;
  logic        operation = 1'b0;
  logic [1:0]  paddle_line = 2'd0;
  logic        paddle_active = 1'b0;
  logic [47:0] now_time = '0;
  logic        out_valid, out_ready = 1'b0;
  logic        key_down, event_element, squeeze_detected;
  logic [1:0]  element_event, memory_armed;
  logic [47:0] event_time;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  int          fail_count, pending_results;
  int          quiet_cycles;
  logic [47:0] clock_us;

  localparam int QUIET_LIMIT = 20000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  iambic_paddle_keyer u_dut (.*);
  iambic_paddle_keyer_checker u_chk (.*);

  // receiver stall pattern
  always @(negedge clk) begin
    int s;
    s = $urandom_range(0, 15);
    out_ready <= (s < 3) ? 1'b0 : ((s < 5) ? out_ready : 1'b1);
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [1:0] line, input logic act,
                           input logic [47:0] t);
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    paddle_line <= line;
    paddle_active <= act;
    now_time <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic tick(input int adv);
    clock_us = clock_us + 48'(adv);
    send_item(1'b1, 2'd0, 1'b0, clock_us);
  endtask

  task automatic paddle(input logic [1:0] line, input logic act);
    send_item(1'b0, line, act, 48'($urandom()));
  endtask

  task automatic drain();
    while (pending_results != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random traffic: mostly ticks of up to step_max, with paddle presses mixed in
  task automatic random_traffic(input int n, input int step_max);
    int k, r, burst;
    k = 0;
    while (k < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 30) paddle(2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else if (r < 33) paddle(2'($urandom_range(2, 3)), 1'($urandom_range(0, 1)));
        else if (r < 36) send_item(1'b1, 2'($urandom()), 1'($urandom()), 48'($urandom()));
        else tick(int'($urandom_range(0, step_max)));
        k++;
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  initial begin
    clock_us = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single paddles, squeeze, ignored lines, extreme times
    paddle(LINE_DIT, 1'b1);
    tick(0);
    tick(30000);
    tick(60000);
    paddle(LINE_DAH, 1'b1);
    tick(30000);
    tick(70000);
    tick(60000);
    tick(200000);
    paddle(LINE_DIT, 1'b0);
    tick(200000);
    paddle(LINE_DAH, 1'b0);
    paddle(2'd2, 1'b1);
    paddle(2'd3, 1'b1);
    tick(400000);
    tick(400000);
    send_item(1'b1, 2'd3, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_item(1'b1, 2'd0, 1'b0, 48'h0);
    drain();

    // extreme settings: fast, long weights, narrow window, live squeeze mode A
    write_reg(REG_SPEED, 7'd100);
    write_reg(REG_DASH, 7'd90);
    write_reg(REG_GAP, 7'd0);
    write_reg(REG_DITW, 7'd99);
    write_reg(REG_WOPEN, 7'd40);
    write_reg(REG_WCLOSE, 7'd100);
    write_reg(REG_MODES, 7'd14);
    clock_us = 48'hFFFF_FFF0_0000;
    random_traffic(150, 40000);
    drain();

    // slow, short weights, closed window, zero speed
    write_reg(REG_SPEED, 7'd0);
    write_reg(REG_DASH, 7'd10);
    write_reg(REG_GAP, 7'd99);
    write_reg(REG_DITW, 7'd10);
    write_reg(REG_WOPEN, 7'd100);
    write_reg(REG_WCLOSE, 7'd0);
    write_reg(REG_MODES, 7'd1);
    clock_us = 0;
    random_traffic(100, 600000);
    drain();

    // out-of-range values and mode B with both memories
    write_reg(REG_SPEED, 7'd127);
    write_reg(REG_DASH, 7'd127);
    write_reg(REG_GAP, 7'd127);
    write_reg(REG_DITW, 7'd127);
    write_reg(REG_WOPEN, 7'd0);
    write_reg(REG_WCLOSE, 7'd127);
    write_reg(REG_MODES, 7'd7);
    random_traffic(150, 30000);
    drain();

    // everyday settings with random bits in the registers
    write_reg(REG_SPEED, 7'($urandom_range(15, 40)));
    write_reg(REG_DASH, 7'd30);
    write_reg(REG_GAP, 7'd50);
    write_reg(REG_DITW, 7'd50);
    write_reg(REG_WOPEN, 7'd20);
    write_reg(REG_WCLOSE, 7'd85);
    write_reg(REG_MODES, 7'($urandom_range(0, 15)));
    random_traffic(230, 90000);

    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
